/* hw/rtl/bbp_pkg.sv */
// Shared types, constants and the two-bit counter update for the branch predictor.
// No dependencies; the top level and bbp_core use it by scoped names.
package bbp_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 4096;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned STATE_W = 2;

	typedef enum logic [STATE_W-1:0] {
		ST_SNT = 2'd0,
		ST_WNT = 2'd1,
		ST_WT  = 2'd2,
		ST_ST  = 2'd3
	} ctr_state_t;

	// Hysteresis update: a miss from a weak state jumps to the opposite strong state.
	function automatic ctr_state_t next_state(input ctr_state_t st, input logic taken);
		ctr_state_t nxt;
		case (st)
			ST_ST:   nxt = taken ? ST_ST : ST_WT;
			ST_WT:   nxt = taken ? ST_ST : ST_SNT;
			ST_WNT:  nxt = taken ? ST_ST : ST_SNT;
			ST_SNT:  nxt = taken ? ST_WNT : ST_SNT;
			default: nxt = ST_SNT;
		endcase
		return nxt;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

/* hw/rtl/two_bit_branch_predictor.sv */
// Top level of the two-bit bimodal branch predictor (hysteresis update).
// Uses bbp_pkg, bbp_ram, bbp_clear and bbp_core.
//
// channel  | ports                                                    | handshake
// ---------+----------------------------------------------------------+------------------
// input    | branch_address[47:0], outcome_taken                       | start && !busy
// result   | predicted_taken, was_correct, correct_total, branch_total | done, one cycle
//
// One word per cycle while busy is low; the word is registered into stage s1, and done
// and the result word are registered from s1.
// The pattern table RAM is read on the accept edge and written back from stage s1;
// a bypass register covers a back-to-back word that hits the same entry.
// After reset busy stays high while all 2**floor(log2(TABLE_ENTRIES)) entries of the
// table are cleared to weakly taken, one entry a cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module two_bit_branch_predictor #(
	parameter int unsigned TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bbp_pkg::ADDR_W-1:0]  branch_address,
	input  logic                        outcome_taken,
	output logic                        done,
	output logic                        predicted_taken,
	output logic                        was_correct,
	output logic [bbp_pkg::CNT_W-1:0]   correct_total,
	output logic [bbp_pkg::CNT_W-1:0]   branch_total
);

	// Only the lowest power-of-two part of the table is ever addressed.
	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES + 1) - 1;
	localparam int unsigned DEPTH = 1 << IDX_W;

	logic                         clr_busy;
	logic [IDX_W-1:0]             clr_addr;
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	logic [bbp_pkg::STATE_W-1:0]  ram_wdata;
	logic                         ram_re;
	logic [IDX_W-1:0]             ram_raddr;
	logic [bbp_pkg::STATE_W-1:0]  ram_rdata;

	bbp_clear #(
		.IDX_W (IDX_W)
	) u_clear (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_busy (clr_busy),
		.clr_addr (clr_addr)
	);

	bbp_ram #(
		.WIDTH (bbp_pkg::STATE_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bbp_core #(
		.IDX_W (IDX_W)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.branch_address  (branch_address),
		.outcome_taken   (outcome_taken),
		.clr_busy        (clr_busy),
		.clr_addr        (clr_addr),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.busy            (busy),
		.done            (done),
		.predicted_taken (predicted_taken),
		.was_correct     (was_correct),
		.correct_total   (correct_total),
		.branch_total    (branch_total)
	);

endmodule

/* hw/rtl/bbp_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Read returns the old contents when reading and writing one address together.
module bbp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/bbp_clear.sv */
// Post-reset clearing sequencer: walks every table entry once, one per cycle.
// Depends on nothing but the index width handed down from the top level.
module bbp_clear #(
	parameter int unsigned IDX_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             clr_busy,
	output logic [IDX_W-1:0] clr_addr
);

	logic             clearing_q;
	logic [IDX_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			cnt_q      <= '0;
		end else if (clearing_q) begin
			cnt_q <= cnt_q + {{(IDX_W-1){1'b0}}, 1'b1};
			if (cnt_q == {IDX_W{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clr_busy = clearing_q;
	assign clr_addr = cnt_q;

endmodule

/* hw/rtl/bbp_core.sv */
// Read-modify-write pipeline of the predictor: forwarding, counter update, result registers.
// Uses bbp_pkg; drives the table RAM ports, muxing in the clearing writes.
module bbp_core #(
	parameter int unsigned IDX_W = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bbp_pkg::ADDR_W-1:0]   branch_address,
	input  logic                         outcome_taken,
	input  logic                         clr_busy,
	input  logic [IDX_W-1:0]             clr_addr,
	output logic                         ram_we,
	output logic [IDX_W-1:0]             ram_waddr,
	output logic [bbp_pkg::STATE_W-1:0]  ram_wdata,
	output logic                         ram_re,
	output logic [IDX_W-1:0]             ram_raddr,
	input  logic [bbp_pkg::STATE_W-1:0]  ram_rdata,
	output logic                         busy,
	output logic                         done,
	output logic                         predicted_taken,
	output logic                         was_correct,
	output logic [bbp_pkg::CNT_W-1:0]    correct_total,
	output logic [bbp_pkg::CNT_W-1:0]    branch_total
);

	logic                       accept;
	logic                       v_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic                       taken_s1;
	logic                       fwd_v_q;
	logic [IDX_W-1:0]           fwd_idx_q;
	bbp_pkg::ctr_state_t        fwd_st_q;
	bbp_pkg::ctr_state_t        cur_st;
	bbp_pkg::ctr_state_t        nxt_st;
	logic                       pred;
	logic                       hit;
	logic                       done_q;
	logic                       pred_q;
	logic                       ok_q;
	logic [bbp_pkg::CNT_W-1:0]  correct_q;
	logic [bbp_pkg::CNT_W-1:0]  branch_q;

	assign busy   = clr_busy;
	assign accept = start && !clr_busy;

	assign ram_re    = accept;
	assign ram_raddr = branch_address[IDX_W-1:0];

	// The previous word's write lands on the same edge as this word's read: take it from the bypass.
	always_comb begin
		if (fwd_v_q && (fwd_idx_q == idx_s1)) begin
			cur_st = fwd_st_q;
		end else begin
			cur_st = bbp_pkg::ctr_state_t'(ram_rdata);
		end
		nxt_st = bbp_pkg::next_state(cur_st, taken_s1);
		pred   = cur_st[1];
		hit    = (pred == taken_s1);
	end

	always_comb begin
		if (clr_busy) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr;
			ram_wdata = bbp_pkg::ST_WT;
		end else begin
			ram_we    = v_s1;
			ram_waddr = idx_s1;
			ram_wdata = nxt_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			fwd_v_q   <= 1'b0;
			done_q    <= 1'b0;
			correct_q <= '0;
			branch_q  <= '0;
		end else begin
			v_s1    <= accept;
			fwd_v_q <= v_s1;
			done_q  <= v_s1;
			if (v_s1) begin
				branch_q <= bbp_pkg::sat_inc(branch_q);
				if (hit) begin
					correct_q <= bbp_pkg::sat_inc(correct_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= branch_address[IDX_W-1:0];
			taken_s1 <= outcome_taken;
		end
		if (v_s1) begin
			fwd_idx_q <= idx_s1;
			fwd_st_q  <= nxt_st;
			pred_q    <= pred;
			ok_q      <= hit;
		end
	end

	assign done            = done_q;
	assign predicted_taken = pred_q;
	assign was_correct     = ok_q;
	assign correct_total   = correct_q;
	assign branch_total    = branch_q;

	a_no_word_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !clr_busy)
		else $error("pipeline word in flight during table clear");

	a_done_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> done_q)
		else $error("result strobe missing after pipeline stage");

	a_correct_le_branch: assert property (@(posedge clk) disable iff (!arst_n)
		correct_q <= branch_q)
		else $error("correct count exceeds branch count");

	a_branch_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (branch_q != {bbp_pkg::CNT_W{1'b1}})) |=> (branch_q != $past(branch_q)))
		else $error("branch count did not advance");

endmodule
